/* src/area_weighted_line_upscaler_core_macros.svh */
// ----------------------------------------------------------------------------
// area weighted line upscaler assertion macros
// shared concurrent assertion forms, clocked on clock, quiet during reset
// ----------------------------------------------------------------------------
`ifndef AREA_WEIGHTED_LINE_UPSCALER_CORE_MACROS_SVH
`define AREA_WEIGHTED_LINE_UPSCALER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define AWLU_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// condition holds on every cycle out of reset
`define AWLU_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed");

`endif

/* src/awlu_pkg.sv */
// ----------------------------------------------------------------------------
// awlu_pkg
// shared types and constants of the area weighted line upscaler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package awlu_pkg;

   localparam int FRAC_BITS = 12;
   localparam int COV_W     = 17;
   localparam int CNT_W     = 12;
   localparam int COL_W     = 11;
   localparam int WGT_W     = FRAC_BITS + 1;

   localparam logic [COV_W-1:0] ONE_Q     = COV_W'(1 << FRAC_BITS);
   localparam logic [COV_W-1:0] RATIO_MAX = COV_W'(16 * (1 << FRAC_BITS));
   localparam logic [CNT_W-1:0] MAX_LINE  = CNT_W'(2048);
   localparam logic [WGT_W-1:0] WGT_ONE   = WGT_W'(1 << FRAC_BITS);

   localparam logic CSR_RATIO  = 1'b0;
   localparam logic CSR_LENGTH = 1'b1;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      pixel_type        pixel;
      logic [COL_W-1:0] column;
      logic             line_done;
   } out_item_type;

   typedef struct packed {
      logic                 start;
      logic [FRAC_BITS-1:0] frac;
      pixel_type            prev;
      pixel_type            cur;
   } blend_req_type;

   typedef struct packed {
      logic      done;
      pixel_type pixel;
   } blend_res_type;

   typedef enum logic [3:0] {
      S_IDLE       = 4'b0001,
      S_BLEND      = 4'b0010,
      S_EMIT_BLEND = 4'b0100,
      S_COPY       = 4'b1000
   } state_type;

endpackage

/* src/awlu_blend_unit.sv */
// ----------------------------------------------------------------------------
// awlu_blend_unit
// shared multiplier that blends two pixels one weighted term per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module awlu_blend_unit
   import awlu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  blend_req_type req,
   output blend_res_type res
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [2:0]           step_ff, step_in;
   logic [FRAC_BITS-1:0] frac_ff, frac_in;
   pixel_type            prev_ff, prev_in;
   pixel_type            cur_ff, cur_in;
   logic [8:0]           acc_ff, acc_in;
   pixel_type            res_ff, res_in;

   logic [7:0]        operand;
   logic [WGT_W-1:0]  weight;
   logic [WGT_W+7:0]  product;
   logic [8:0]        term;
   logic [8:0]        sum;
   pixel_type         src;

   always_comb begin
      src = step_ff[0] ? cur_ff : prev_ff;
      case (step_ff[2:1])
         2'd0:    operand = src.red;
         2'd1:    operand = src.green;
         default: operand = src.blue;
      endcase
      weight  = step_ff[0] ? (WGT_ONE - {1'b0, frac_ff}) : {1'b0, frac_ff};
      product = (WGT_W+8)'(weight) * (WGT_W+8)'(operand);
      term    = product[WGT_W+7:FRAC_BITS];
      sum     = step_ff[0] ? (acc_ff + term) : term;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      frac_in = frac_ff;
      prev_in = prev_ff;
      cur_in  = cur_ff;
      acc_in  = acc_ff;
      res_in  = res_ff;
      if (req.start) begin
         busy_in = 1'b1;
         step_in = 3'd0;
         frac_in = req.frac;
         prev_in = req.prev;
         cur_in  = req.cur;
      end else if (busy_ff) begin
         acc_in = sum;
         if (step_ff[0]) begin
            case (step_ff[2:1])
               2'd0:    res_in.red   = sum[7:0];
               2'd1:    res_in.green = sum[7:0];
               default: res_in.blue  = sum[7:0];
            endcase
         end
         if (step_ff == 3'd5) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      frac_ff <= frac_in;
      prev_ff <= prev_in;
      cur_ff  <= cur_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
   end

   assign res.done  = done_ff;
   assign res.pixel = res_ff;

endmodule

/* src/awlu_out_reg.sv */
// ----------------------------------------------------------------------------
// awlu_out_reg
// output register that holds one result transaction for the rsp channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module awlu_out_reg
   import awlu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  out_item_type item,
   output logic         can_load,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,
   output logic         rsp_tlast
);

   logic         valid_ff, valid_in;
   out_item_type item_ff, item_in;

   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = item;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'b0, item_ff.column, item_ff.pixel.blue,
                        item_ff.pixel.green, item_ff.pixel.red};
   assign rsp_tlast  = item_ff.line_done;

endmodule

/* src/area_weighted_line_upscaler_core.sv */
// ----------------------------------------------------------------------------
// area_weighted_line_upscaler_core
// horizontal area weighted upscaler: blends the owed fraction, then copies
//
// channel   direction  contents
// req_*     in         tdata red/green/blue, tuser first_of_line, tlast last
// rsp_*     out        tdata red/green/blue/out_column, tlast line_done
// csr_*     in         register index and write data, always ready
//
// a source pixel is accepted in S_IDLE, goes through the shared blend
// multiplier in S_BLEND (six weighted terms, skipped on the first pixel of
// a line), emits its outputs from S_EMIT_BLEND and S_COPY and then closes;
// a line's last pixel adds another blend, output and close plus its copies
// for the trailing blend with zero; a full output register with rsp_tready
// low stalls the sequencer at the next output; req_tready is high only
// between pixels; synchronous reset clears the sequencer and the line state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "area_weighted_line_upscaler_core_macros.svh"

module area_weighted_line_upscaler_core
   import awlu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red_in, green_in, blue_in
   input  logic        req_tuser,   // first_of_line
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // red_out, green_out, blue_out, out_column
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [16:0] csr_data
);

   logic [COV_W-1:0] ratio_ff;
   logic [CNT_W-1:0] length_ff;

   state_type        state_ff, state_in;
   logic [COV_W-1:0] cov_ff, cov_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   pixel_type        held_ff, held_in;
   logic             held_valid_ff, held_valid_in;
   pixel_type        cur_ff, cur_in;
   logic             last_ff, last_in;
   logic             tail_ff, tail_in;

   logic [COV_W-1:0] ratio_eff;
   logic [CNT_W-1:0] len_eff;
   logic [COV_W-1:0] cov_blend;
   logic [COV_W-1:0] cov_dec;
   logic [CNT_W-1:0] cnt_inc;
   logic             done_norm;
   logic             cov_ge_one;
   logic             cnt_lt_len;
   logic             more_blend;
   logic             more_copy;
   logic             req_accept;
   pixel_type        req_pixel;

   blend_req_type    blend_req;
   blend_res_type    blend_res;
   logic             out_load;
   logic             out_ready;
   out_item_type     out_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff  <= COV_W'(8192);
         length_ff <= CNT_W'(2048);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RATIO:  ratio_ff  <= csr_data;
            CSR_LENGTH: length_ff <= csr_data[CNT_W-1:0];
            default:    ratio_ff  <= ratio_ff;
         endcase
      end
   end

   always_comb begin
      if (ratio_ff < ONE_Q) ratio_eff = ONE_Q;
      else if (ratio_ff > RATIO_MAX) ratio_eff = RATIO_MAX;
      else ratio_eff = ratio_ff;
      len_eff    = (length_ff > MAX_LINE) ? MAX_LINE : length_ff;
      cov_blend  = ratio_eff - ONE_Q + {{(COV_W-FRAC_BITS){1'b0}}, cov_ff[FRAC_BITS-1:0]};
      cov_dec    = cov_ff - ONE_Q;
      cnt_inc    = cnt_ff + CNT_W'(1);
      done_norm  = ({1'b0, cnt_ff} + (CNT_W+1)'(1)) >= {1'b0, len_eff};
      cov_ge_one = cov_ff >= ONE_Q;
      cnt_lt_len = cnt_ff < len_eff;
      more_blend = (cov_blend >= ONE_Q) && (cnt_inc < len_eff);
      more_copy  = (cov_dec >= ONE_Q) && (cnt_inc < len_eff);
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_pixel  = '{red: req_tdata[7:0], green: req_tdata[15:8], blue: req_tdata[23:16]};

   always_comb begin
      state_in      = state_ff;
      cov_in        = cov_ff;
      cnt_in        = cnt_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      cur_in        = cur_ff;
      last_in       = last_ff;
      tail_in       = tail_ff;
      out_load      = 1'b0;
      out_item      = '{pixel: cur_ff, column: cnt_ff[COL_W-1:0], line_done: done_norm};
      blend_req     = '{start: 1'b0, frac: cov_ff[FRAC_BITS-1:0], prev: held_ff,
                        cur: req_pixel};
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cur_in  = req_pixel;
               last_in = req_tlast;
               tail_in = 1'b0;
               if (req_tuser) begin
                  cov_in   = ratio_eff;
                  cnt_in   = '0;
                  state_in = S_COPY;
               end else if (held_valid_ff) begin
                  if (cnt_lt_len) begin
                     blend_req.start = 1'b1;
                     state_in        = S_BLEND;
                  end else begin
                     held_in       = req_pixel;
                     held_valid_in = 1'b0;
                  end
               end
            end
         end
         S_BLEND: begin
            if (blend_res.done) begin
               state_in = S_EMIT_BLEND;
            end
         end
         S_EMIT_BLEND: begin
            out_item.pixel     = blend_res.pixel;
            out_item.line_done = done_norm || (tail_ff && !more_blend);
            if (out_ready) begin
               out_load = 1'b1;
               cov_in   = cov_blend;
               cnt_in   = cnt_inc;
               state_in = S_COPY;
            end
         end
         S_COPY: begin
            out_item.line_done = done_norm || (tail_ff && !more_copy);
            if (cov_ge_one && cnt_lt_len) begin
               if (out_ready) begin
                  out_load = 1'b1;
                  cov_in   = cov_dec;
                  cnt_in   = cnt_inc;
               end
            end else if (tail_ff) begin
               held_in       = '0;
               held_valid_in = 1'b0;
               state_in      = S_IDLE;
            end else begin
               held_in       = cur_ff;
               held_valid_in = cnt_lt_len;
               if (last_ff && cnt_lt_len) begin
                  blend_req.start = 1'b1;
                  blend_req.prev  = cur_ff;
                  blend_req.cur   = '0;
                  cur_in          = '0;
                  tail_in         = 1'b1;
                  state_in        = S_BLEND;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cov_ff        <= '0;
         cnt_ff        <= '0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         last_ff       <= 1'b0;
         tail_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cov_ff        <= cov_in;
         cnt_ff        <= cnt_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         last_ff       <= last_in;
         tail_ff       <= tail_in;
      end
      cur_ff <= cur_in;
   end

   awlu_blend_unit u_blend (
      .clock (clock),
      .reset (reset),
      .req   (blend_req),
      .res   (blend_res)
   );

   awlu_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .item       (out_item),
      .can_load   (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `AWLU_ASSERT_SAME(a_blend_done_in_blend, blend_res.done, state_ff == S_BLEND)
   `AWLU_ASSERT_SAME(a_load_in_emit, out_load, (state_ff == S_EMIT_BLEND) || (state_ff == S_COPY))
   `AWLU_ASSERT_ALWAYS(a_count_bounded, cnt_ff <= MAX_LINE)

endmodule

/* tb/sv/upscaled_pixel_checker.sv */
// ----------------------------------------------------------------------------
// upscaled_pixel_checker
// watches the source, output and register channels of the line upscaler,
// predicts every output pixel from the accepted source pixels and register
// writes, and compares each output transaction field by field in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module upscaled_pixel_checker
   import awlu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // red_in, green_in, blue_in
   input  logic        req_tuser,   // first_of_line
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // red_out, green_out, blue_out, out_column
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [16:0] csr_data,
   output int          mismatch_count,
   output int          pending_count,
   output int          checked_count
);

   logic [COV_W-1:0] ratio_reg;
   logic [CNT_W-1:0] length_reg;

   logic [COV_W-1:0] coverage;
   pixel_type        held_pixel;
   logic [CNT_W-1:0] emitted;
   logic             held_valid;
   int               step_outputs;

   out_item_type     expected_pixels[$];
   out_item_type     seen;
   out_item_type     want;
   pixel_type        source_pixel;

   function automatic logic [COV_W-1:0] clamped_ratio();
      if (ratio_reg < ONE_Q) return ONE_Q;
      if (ratio_reg > RATIO_MAX) return RATIO_MAX;
      return ratio_reg;
   endfunction

   function automatic logic [CNT_W-1:0] clamped_length();
      return (length_reg > MAX_LINE) ? MAX_LINE : length_reg;
   endfunction

   // each weighted term is truncated on its own
   function automatic logic [7:0] mix_channel(input logic [FRAC_BITS-1:0] frac,
                                              input logic [7:0] prev,
                                              input logic [7:0] cur);
      int held_term;
      int cur_term;
      held_term = (int'(frac) * int'(prev)) >> FRAC_BITS;
      cur_term  = ((int'(WGT_ONE) - int'(frac)) * int'(cur)) >> FRAC_BITS;
      return 8'(held_term + cur_term);
   endfunction

   function automatic pixel_type mix_pixels(input logic [FRAC_BITS-1:0] frac,
                                            input pixel_type prev,
                                            input pixel_type cur);
      pixel_type result;
      result.red   = mix_channel(frac, prev.red, cur.red);
      result.green = mix_channel(frac, prev.green, cur.green);
      result.blue  = mix_channel(frac, prev.blue, cur.blue);
      return result;
   endfunction

   function automatic void push_output(input pixel_type px, input logic [CNT_W-1:0] len);
      out_item_type item;
      item.pixel     = px;
      item.column    = emitted[COL_W-1:0];
      item.line_done = (int'(emitted) + 1 >= int'(len));
      expected_pixels.push_back(item);
      emitted = emitted + 1'b1;
      step_outputs++;
   endfunction

   function automatic void push_copies(input pixel_type px, input logic [CNT_W-1:0] len);
      while (coverage >= ONE_Q && emitted < len) begin
         push_output(px, len);
         coverage = coverage - ONE_Q;
      end
   endfunction

   // owed blend of the held pixel with cur, then the copies of cur
   function automatic void push_advance(input pixel_type cur, input logic [CNT_W-1:0] len);
      logic [FRAC_BITS-1:0] frac;
      if (emitted >= len) return;
      frac = coverage[FRAC_BITS-1:0];
      push_output(mix_pixels(frac, held_pixel, cur), len);
      coverage = clamped_ratio() - (ONE_Q - COV_W'(frac));
      push_copies(cur, len);
   endfunction

   function automatic void predict_source_pixel(input pixel_type px, input logic first,
                                                input logic last);
      logic [CNT_W-1:0] len;
      out_item_type     tail;
      len = clamped_length();
      step_outputs = 0;
      if (first) begin
         coverage = clamped_ratio();
         emitted  = '0;
         push_copies(px, len);
      end else if (held_valid) begin
         push_advance(px, len);
      end else begin
         return;
      end
      held_pixel = px;
      held_valid = (emitted < len);
      if (last && held_valid) begin
         push_advance('0, len);
         held_pixel = '0;
         held_valid = 1'b0;
         if (step_outputs > 0) begin
            tail = expected_pixels.pop_back();
            tail.line_done = 1'b1;
            expected_pixels.push_back(tail);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         ratio_reg      = COV_W'(8192);
         length_reg     = CNT_W'(2048);
         coverage       = '0;
         held_pixel     = '0;
         emitted        = '0;
         held_valid     = 1'b0;
         expected_pixels.delete();
         mismatch_count = 0;
         checked_count  = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_RATIO) ratio_reg = csr_data;
            else if (csr_index == CSR_LENGTH) length_reg = csr_data[CNT_W-1:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.pixel.red   = rsp_tdata[7:0];
            seen.pixel.green = rsp_tdata[15:8];
            seen.pixel.blue  = rsp_tdata[23:16];
            seen.column      = rsp_tdata[24 +: COL_W];
            seen.line_done   = rsp_tlast;
            checked_count++;
            if (expected_pixels.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected output rgb %h col %0d done %b", $realtime,
                           seen.pixel, seen.column, seen.line_done);
            end else begin
               want = expected_pixels.pop_front();
               if (seen.pixel.red !== want.pixel.red || seen.pixel.green !== want.pixel.green ||
                   seen.pixel.blue !== want.pixel.blue || seen.column !== want.column ||
                   seen.line_done !== want.line_done) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: output mismatch exp rgb %h col %0d done %b, got rgb %h col %0d done %b",
                              $realtime, want.pixel, want.column, want.line_done,
                              seen.pixel, seen.column, seen.line_done);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            source_pixel.red   = req_tdata[7:0];
            source_pixel.green = req_tdata[15:8];
            source_pixel.blue  = req_tdata[23:16];
            predict_source_pixel(source_pixel, req_tuser, req_tlast);
         end
      end
      pending_count = expected_pixels.size();
   end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// drives source pixel lines and register settings into the line upscaler
// with bursty input and a stalling output side, and reports the verdict of
// the output pixel checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
   import awlu_pkg::*;
();

   localparam int RANDOM_ITEMS  = 90;
   localparam int SETTLE_CYCLES = 64;
   localparam int STALL_LIMIT   = 2000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // red_in, green_in, blue_in
   logic        req_tuser;   // first_of_line
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // red_out, green_out, blue_out, out_column
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [16:0] csr_data;

   int mismatch_count;
   int pending_count;
   int checked_count;
   int quiet_cycles;
   int burst_left;
   int pixels_sent;
   int settings_used;

   area_weighted_line_upscaler_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   upscaled_pixel_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // output side backpressure, switching between a few stall patterns
   initial begin
      int mode;
      int stretch;
      int phase;
      rsp_tready = 1'b0;
      mode = 0;
      stretch = 0;
      phase = 0;
      forever begin
         @(negedge clock);
         if (stretch == 0) begin
            mode = $urandom_range(0, 3);
            stretch = $urandom_range(20, 80);
         end
         stretch--;
         phase++;
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ((phase % 7) < 3);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d outputs still expected",
                  STALL_LIMIT, pending_count);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_pixel(input pixel_type px, input logic first, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {px.blue, px.green, px.red};
      req_tuser  <= first;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
   endtask

   // wait until the block has nothing left to produce
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic write_csr(input logic idx, input logic [16:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_scale(input logic [16:0] ratio, input logic [16:0] length_word);
      settle();
      write_csr(CSR_RATIO, ratio);
      write_csr(CSR_LENGTH, length_word);
      settings_used++;
   endtask

   function automatic logic [7:0] random_channel();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      px.red   = random_channel();
      px.green = random_channel();
      px.blue  = random_channel();
      return px;
   endfunction

   initial begin
      int random_sent;
      int kind;
      int count;
      logic [16:0] ratio;
      logic [11:0] length_val;
      logic first;
      logic last;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = CSR_RATIO;
      csr_data   = '0;
      burst_left = 0;
      pixels_sent = 0;
      settings_used = 0;
      random_sent = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset setting: 2.0 ratio, full length; pixels outside a line first
      send_pixel(pixel_type'(24'h000000), 1'b0, 1'b0);
      send_pixel(pixel_type'(24'h123456), 1'b0, 1'b1);
      send_pixel(pixel_type'(24'hFFFFFF), 1'b1, 1'b0);
      send_pixel(pixel_type'(24'h000000), 1'b0, 1'b0);
      send_pixel(pixel_type'(24'hFF0080), 1'b0, 1'b1);
      send_pixel(pixel_type'(24'h123456), 1'b1, 1'b1);

      // unit ratio, length above the line maximum
      set_scale(17'd4096, 17'd4095);
      send_pixel(pixel_type'(24'h00FF00), 1'b1, 1'b0);
      send_pixel(pixel_type'(24'h0000FF), 1'b0, 1'b0);
      send_pixel(pixel_type'(24'h808080), 1'b0, 1'b1);

      // largest ratio, single-pixel output line, then pixels after the line ended
      set_scale(17'd65536, 17'd1);
      send_pixel(pixel_type'(24'hAA55AA), 1'b1, 1'b0);
      send_pixel(pixel_type'(24'h55AA55), 1'b0, 1'b0);
      send_pixel(pixel_type'(24'hFFFFFF), 1'b0, 1'b1);

      // ratio above range, most outputs per pixel
      set_scale(17'h1FFFF, 17'd2048);
      send_pixel(pixel_type'(24'hFFFFFF), 1'b1, 1'b0);
      send_pixel(pixel_type'(24'h010203), 1'b0, 1'b0);
      send_pixel(pixel_type'(24'hFEFDFC), 1'b0, 1'b1);

      // ratio below range, zero length
      set_scale(17'd0, 17'd0);
      send_pixel(pixel_type'(24'h7F7F7F), 1'b1, 1'b0);
      send_pixel(pixel_type'(24'h808080), 1'b0, 1'b1);

      // fractional ratio, line cut by length, restart while a line is open
      set_scale(17'd6144, 17'd5);
      send_pixel(pixel_type'(24'h102030), 1'b1, 1'b0);
      send_pixel(pixel_type'(24'h405060), 1'b0, 1'b0);
      send_pixel(pixel_type'(24'hA0B0C0), 1'b1, 1'b0);
      send_pixel(pixel_type'(24'hD0E0F0), 1'b0, 1'b0);
      send_pixel(pixel_type'(24'hFF00FF), 1'b0, 1'b0);
      send_pixel(pixel_type'(24'h0F0F0F), 1'b0, 1'b1);

      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 7))
            0: ratio = 17'd4096;
            1: ratio = 17'd65536;
            2: ratio = 17'($urandom_range(0, 131071));
            3: ratio = 17'd8192;
            default: ratio = 17'($urandom_range(4096, 24576));
         endcase
         case ($urandom_range(0, 7))
            0: length_val = 12'd2048;
            1: length_val = 12'd0;
            2: length_val = 12'($urandom_range(0, 4095));
            3: length_val = 12'd1;
            default: length_val = 12'($urandom_range(2, 40));
         endcase
         set_scale(ratio, {5'($urandom), length_val});
         repeat ($urandom_range(2, 5)) begin
            kind = $urandom_range(0, 9);
            count = $urandom_range(1, 8);
            for (int i = 0; i < count; i++) begin
               first = (i == 0);
               last = (i == count - 1);
               if (kind == 0) first = 1'b0;
               if (kind == 1 && last) last = 1'b0;
               if (kind == 2 && i > 0) first = ($urandom_range(0, 3) == 0);
               send_pixel(random_pixel(), first, last);
               random_sent++;
            end
         end
      end

      settle();
      $display("run covered %0d source pixels over %0d register settings", pixels_sent,
               settings_used + 1);
      $display("%0d output pixels checked, %0d mismatches, %0d still expected",
               checked_count, mismatch_count, pending_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+src
src/awlu_pkg.sv
src/awlu_blend_unit.sv
src/awlu_out_reg.sv
src/area_weighted_line_upscaler_core.sv
tb/sv/upscaled_pixel_checker.sv
tb/sv/tb.sv
